>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the block's own clock and reset.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

>>> design/tts_pkg.sv
package tts_pkg;

    localparam int KEY_W     = 8;
    localparam int PRIO_W    = 8;
    localparam int TSTAT_W   = 2;
    localparam int RES_W     = 2;
    localparam int S_TDATA_W = 24;
    // status + selected key, the low part of the result word
    localparam int RES_FIELDS_W = RES_W + KEY_W;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_REMOVE,
        CMD_SET,
        CMD_PICK
    } cmd_t;

    typedef enum logic [1:0] {
        RES_OK,
        RES_FULL,
        RES_NOT_FOUND,
        RES_NONE_READY
    } res_t;

    localparam logic [TSTAT_W-1:0] TS_READY   = 2'd0;
    localparam logic [TSTAT_W-1:0] TS_RUNNING = 2'd1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PRIO_W-1:0]  prio;
        logic [TSTAT_W-1:0] tstat;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        MATCH_PRIO_ABOVE,
        MATCH_KEY,
        MATCH_RUNNABLE,
        MATCH_READY
    } match_kind_t;

    typedef struct packed {
        match_kind_t       kind;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
    } match_req_t;

endpackage

>>> design/tts_ram.sv
module tts_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/tts_match.sv
module tts_match
    import tts_pkg::*;
(
    input  match_req_t req,
    input  entry_t     ent,
    output logic       hit
);

    always_comb begin
        case (req.kind)
            MATCH_PRIO_ABOVE: hit = ent.prio > req.prio;
            MATCH_KEY:        hit = ent.key == req.key;
            MATCH_RUNNABLE:   hit = (ent.tstat == TS_READY) || (ent.tstat == TS_RUNNING);
            MATCH_READY:      hit = ent.tstat == TS_READY;
            default:          hit = 1'b0;
        endcase
    end

endmodule

>>> design/task_table_scheduler.sv
// Task table scheduler.
// Requests enter on the s_ channel: s_tuser carries the command (add, remove,
// set status, pick next), s_tdata the key, priority and status. Every request
// yields exactly one result on the m_ channel: status code, selected key and
// the table fill after the command. The policy register (cfg_wr_en/cfg_wr_data)
// picks round robin (0) or lowest priority value first (1).
// Timing: one request at a time; s_tready is low while a request is at work
// and rises in the same cycle as the result is registered.
// A refused add, a round-robin add or a remove, set or pick on an empty table
// goes from acceptance straight to the result. Key, priority and pick scans
// read one table entry per cycle through the RAM's registered read port until
// a hit or the last entry. Priority adds and removes then move entries one per
// cycle through the same port, and a priority add finally writes the new entry
// in an insert step.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is accepted, and only a completion waits for it.
// Reset (aresetn, synchronous) empties the table, zeroes the cursor and
// selects round robin. Table contents need no clearing: only entries below
// the fill count are ever read.
module task_table_scheduler
    import tts_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] task_key, [15:8] task_priority, [17:16] task_status, rest zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] status, [9:2] selected_task, then task_count, rest zero
    output logic [((RES_FIELDS_W + $clog2(MAX_TASKS + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int M_TDATA_W = ((RES_FIELDS_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_INSERT,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic                policy_reg, policy_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                rd_last_reg, rd_last_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    cmd_t                cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;
    logic [TSTAT_W-1:0]  tstat_reg, tstat_next;
    match_kind_t         kind_reg, kind_next;
    res_t                res_reg, res_next;
    logic [KEY_W-1:0]    sel_reg, sel_next;
    logic                m_tvalid_reg, m_tvalid_next;
    res_t                m_status_reg, m_status_next;
    logic [KEY_W-1:0]    m_sel_reg, m_sel_next;
    logic [CNT_W-1:0]    m_count_reg, m_count_next;

    cmd_t                in_cmd;
    entry_t              in_ent;
    entry_t              ram_rdata;
    entry_t              ram_wdata;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    match_req_t          match_req;
    logic                hit;
    logic                scan_hit;
    logic                scan_miss;

    function automatic logic [IDX_W-1:0] next_wrap(input logic [IDX_W-1:0] p,
                                                   input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] q;
        q = CNT_W'(p) + CNT_W'(1);
        return (q >= n) ? '0 : q[IDX_W-1:0];
    endfunction

    assign in_cmd       = cmd_t'(s_tuser);
    assign in_ent.key   = s_tdata[KEY_W-1:0];
    assign in_ent.prio  = s_tdata[KEY_W+PRIO_W-1:KEY_W];
    assign in_ent.tstat = s_tdata[KEY_W+PRIO_W+TSTAT_W-1:KEY_W+PRIO_W];

    assign match_req.kind = kind_reg;
    assign match_req.key  = key_reg;
    assign match_req.prio = prio_reg;

    tts_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_TASKS)
    ) u_table (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ptr_reg),
        .rdata(ram_rdata)
    );

    tts_match u_match (
        .req(match_req),
        .ent(ram_rdata),
        .hit(hit)
    );

    assign scan_hit  = rd_vld_reg && hit;
    assign scan_miss = rd_vld_reg && rd_last_reg && !hit;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        policy_next   = cfg_wr_en ? cfg_wr_data : policy_reg;
        ptr_next      = ptr_reg;
        left_next     = left_reg;
        rd_vld_next   = 1'b0;
        rd_last_next  = rd_last_reg;
        rd_idx_next   = rd_idx_reg;
        pos_next      = pos_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        prio_next     = prio_reg;
        tstat_next    = tstat_reg;
        kind_next     = kind_reg;
        res_next      = res_reg;
        sel_next      = sel_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_sel_next    = m_sel_reg;
        m_count_next  = m_count_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata.key   = key_reg;
        ram_wdata.prio  = prio_reg;
        ram_wdata.tstat = tstat_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = in_cmd;
                    key_next   = in_ent.key;
                    prio_next  = in_ent.prio;
                    tstat_next = in_ent.tstat;
                    res_next   = RES_OK;
                    sel_next   = '0;
                    state_next = ST_FINISH;
                    left_next  = count_reg;
                    ptr_next   = '0;
                    case (in_cmd)
                        CMD_ADD: begin
                            if (count_reg == CNT_W'(MAX_TASKS)) begin
                                res_next = RES_FULL;
                            end else if (!policy_reg) begin
                                // round robin appends and points the cursor at it
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg[IDX_W-1:0];
                                ram_wdata   = in_ent;
                                cursor_next = count_reg[IDX_W-1:0];
                                count_next  = count_reg + CNT_W'(1);
                            end else if (count_reg == '0) begin
                                pos_next   = '0;
                                state_next = ST_INSERT;
                            end else begin
                                kind_next  = MATCH_PRIO_ABOVE;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_REMOVE, CMD_SET: begin
                            if (count_reg == '0) begin
                                res_next = RES_NOT_FOUND;
                            end else begin
                                kind_next  = MATCH_KEY;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_PICK: begin
                            if (count_reg == '0) begin
                                res_next = RES_NONE_READY;
                            end else if (policy_reg) begin
                                kind_next  = MATCH_RUNNABLE;
                                state_next = ST_SCAN;
                            end else begin
                                kind_next  = MATCH_READY;
                                ptr_next   = next_wrap(cursor_reg, count_reg);
                                state_next = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN: begin
                if (left_reg != '0 && !scan_hit) begin
                    rd_vld_next  = 1'b1;
                    rd_idx_next  = ptr_reg;
                    rd_last_next = left_reg == CNT_W'(1);
                    ptr_next     = next_wrap(ptr_reg, count_reg);
                    left_next    = left_reg - CNT_W'(1);
                end
                if (scan_hit) begin
                    case (cmd_reg)
                        CMD_ADD: begin
                            // open a slot at the hit index, moving the tail up
                            pos_next   = rd_idx_reg;
                            ptr_next   = IDX_W'(count_reg - CNT_W'(1));
                            left_next  = count_reg - CNT_W'(rd_idx_reg);
                            state_next = ST_SHIFT;
                        end
                        CMD_REMOVE: begin
                            if (CNT_W'(rd_idx_reg) + CNT_W'(1) == count_reg) begin
                                count_next = count_reg - CNT_W'(1);
                                state_next = ST_FINISH;
                            end else begin
                                ptr_next   = rd_idx_reg + IDX_W'(1);
                                left_next  = count_reg - CNT_W'(rd_idx_reg) - CNT_W'(1);
                                state_next = ST_SHIFT;
                            end
                        end
                        CMD_SET: begin
                            ram_we          = 1'b1;
                            ram_waddr       = rd_idx_reg;
                            ram_wdata.key   = ram_rdata.key;
                            ram_wdata.prio  = ram_rdata.prio;
                            ram_wdata.tstat = tstat_reg;
                            state_next      = ST_FINISH;
                        end
                        CMD_PICK: begin
                            sel_next = ram_rdata.key;
                            if (kind_reg == MATCH_READY) begin
                                cursor_next = rd_idx_reg;
                            end
                            state_next = ST_FINISH;
                        end
                        default: ;
                    endcase
                end else if (scan_miss) begin
                    case (cmd_reg)
                        CMD_ADD: begin
                            pos_next   = count_reg[IDX_W-1:0];
                            state_next = ST_INSERT;
                        end
                        CMD_REMOVE, CMD_SET: begin
                            res_next   = RES_NOT_FOUND;
                            state_next = ST_FINISH;
                        end
                        CMD_PICK: begin
                            res_next   = RES_NONE_READY;
                            state_next = ST_FINISH;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SHIFT: begin
                if (left_reg != '0) begin
                    rd_vld_next  = 1'b1;
                    rd_idx_next  = ptr_reg;
                    rd_last_next = left_reg == CNT_W'(1);
                    ptr_next     = (cmd_reg == CMD_ADD) ? ptr_reg - IDX_W'(1)
                                                        : ptr_reg + IDX_W'(1);
                    left_next    = left_reg - CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = (cmd_reg == CMD_ADD) ? rd_idx_reg + IDX_W'(1)
                                                     : rd_idx_reg - IDX_W'(1);
                    ram_wdata = ram_rdata;
                    if (rd_last_reg) begin
                        if (cmd_reg == CMD_ADD) begin
                            state_next = ST_INSERT;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            ST_INSERT: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_reg;
                    m_sel_next    = sel_reg;
                    m_count_next  = count_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            policy_reg   <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            policy_reg   <= policy_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ptr_reg      <= ptr_next;
        left_reg     <= left_next;
        rd_last_reg  <= rd_last_next;
        rd_idx_reg   <= rd_idx_next;
        pos_reg      <= pos_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        prio_reg     <= prio_next;
        tstat_reg    <= tstat_next;
        kind_reg     <= kind_next;
        res_reg      <= res_next;
        sel_reg      <= sel_next;
        m_status_reg <= m_status_next;
        m_sel_reg    <= m_sel_next;
        m_count_reg  <= m_count_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_count_reg, m_sel_reg, m_status_reg});

endmodule

>>> design/tts_checker.sv
`include "assert_macros.svh"

module tts_checker
    import tts_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((RES_FIELDS_W + $clog2(MAX_TASKS + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int CNT_HI = RES_FIELDS_W + CNT_W - 1;

    // s_tready drops in the cycle after a request is taken, so the next one waits
    `ASSERT_STD(a_busy_after_request, s_tvalid && s_tready |=> !s_tready, "ready right after request")

    `ASSERT_STD(a_result_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

    `ASSERT_STD(a_full_at_capacity, m_tvalid && (m_tdata[RES_W-1:0] == RES_FULL) |-> (m_tdata[CNT_HI:RES_FIELDS_W] == CNT_W'(MAX_TASKS)), "table full reported below capacity")

    `ASSERT_STD(a_no_key_on_error, m_tvalid && (m_tdata[RES_W-1:0] != RES_OK) |-> (m_tdata[RES_FIELDS_W-1:RES_W] == '0), "selected key set on failed request")

endmodule

bind task_table_scheduler tts_checker #(
    .MAX_TASKS(MAX_TASKS)
) u_tts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

>>> tb/tts_checker.sv
module tts_scoreboard
    import tts_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int M_W       = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_W-1:0]       m_tdata,
    output int                   fail_count,
    output int                   waiting,
    output int                   checked
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef struct {
        res_t             code;
        logic [KEY_W-1:0] sel;
        int               fill;
    } outcome_t;

    // shadow of the task table
    logic [KEY_W-1:0]   tbl_key  [MAX_TASKS];
    logic [PRIO_W-1:0]  tbl_prio [MAX_TASKS];
    logic [TSTAT_W-1:0] tbl_stat [MAX_TASKS];
    int                 fill;
    int                 cursor;
    bit                 prio_mode;

    outcome_t pending_results[$];

    function automatic int lookup_key(input logic [KEY_W-1:0] k);
        for (int i = 0; i < fill; i++)
            if (tbl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic outcome_t apply_command(input cmd_t cmd, input logic [KEY_W-1:0] k,
                                               input logic [PRIO_W-1:0] p,
                                               input logic [TSTAT_W-1:0] st);
        outcome_t o;
        int pos;
        int idx;
        int c;
        o.code = RES_OK;
        o.sel  = '0;
        case (cmd)
            CMD_ADD: begin
                if (fill >= MAX_TASKS) begin
                    o.code = RES_FULL;
                end else begin
                    if (!prio_mode) begin
                        pos    = fill;
                        cursor = pos;
                    end else begin
                        // goes after entries of equal priority
                        pos = 0;
                        while (pos < fill && tbl_prio[pos] <= p) pos++;
                        for (idx = fill; idx > pos; idx--) begin
                            tbl_key[idx]  = tbl_key[idx-1];
                            tbl_prio[idx] = tbl_prio[idx-1];
                            tbl_stat[idx] = tbl_stat[idx-1];
                        end
                    end
                    tbl_key[pos]  = k;
                    tbl_prio[pos] = p;
                    tbl_stat[pos] = st;
                    fill++;
                end
            end
            CMD_REMOVE: begin
                idx = lookup_key(k);
                if (idx < 0) begin
                    o.code = RES_NOT_FOUND;
                end else begin
                    while (idx + 1 < fill) begin
                        tbl_key[idx]  = tbl_key[idx+1];
                        tbl_prio[idx] = tbl_prio[idx+1];
                        tbl_stat[idx] = tbl_stat[idx+1];
                        idx++;
                    end
                    fill--;
                end
            end
            CMD_SET: begin
                idx = lookup_key(k);
                if (idx < 0) o.code = RES_NOT_FOUND;
                else tbl_stat[idx] = st;
            end
            default: begin
                o.code = RES_NONE_READY;
                if (prio_mode) begin
                    for (idx = 0; idx < fill; idx++) begin
                        if (tbl_stat[idx] == TS_READY || tbl_stat[idx] == TS_RUNNING) begin
                            o.code = RES_OK;
                            o.sel  = tbl_key[idx];
                            break;
                        end
                    end
                end else begin
                    // cursor may sit past the end after removals: wraps to 0
                    c = cursor;
                    for (idx = 0; idx < fill; idx++) begin
                        c++;
                        if (c >= fill) c = 0;
                        if (tbl_stat[c] == TS_READY) begin
                            cursor = c;
                            o.code = RES_OK;
                            o.sel  = tbl_key[c];
                            break;
                        end
                    end
                end
            end
        endcase
        o.fill = fill;
        return o;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            fill       = 0;
            cursor     = 0;
            prio_mode  = 1'b0;
            fail_count = 0;
            checked    = 0;
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.code = res_t'(m_tdata[RES_W-1:0]);
                got.sel  = m_tdata[RES_W +: KEY_W];
                got.fill = int'(m_tdata[RES_FIELDS_W +: CNT_W]);
                checked++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d/%0d/%0d",
                             $time, got.code, got.sel, got.fill);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.code, got.code);
                    check_field("selected_task", want.sel, got.sel);
                    check_field("task_count", want.fill, got.fill);
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_command(cmd_t'(s_tuser), s_tdata[KEY_W-1:0],
                                                        s_tdata[KEY_W +: PRIO_W],
                                                        s_tdata[KEY_W+PRIO_W +: TSTAT_W]));
            if (cfg_wr_en) prio_mode = cfg_wr_data;
        end
        waiting <= pending_results.size();
    end

endmodule

>>> tb/tb_top.sv
module tb_top;
    import tts_pkg::*;

    localparam int MAX_TASKS = 16;
    localparam int M_W = ((RES_FIELDS_W + $clog2(MAX_TASKS + 1) + 7) / 8) * 8;
    localparam int STUCK_LIMIT = 2000;
    localparam int POOL_N = 10;

    localparam logic [TSTAT_W-1:0] TS_BLOCKED = 2'd2;
    localparam logic [TSTAT_W-1:0] TS_ODD     = 2'd3;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [1:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_W-1:0]       m_tdata;

    int fail_count;
    int waiting;
    int checked;
    int sent          = 0;
    int policy_writes = 0;
    int stuck         = 0;
    int hold_left     = 0;
    int cycle_no      = 0;
    bit calm          = 1'b0;

    logic [KEY_W-1:0]  key_pool [POOL_N];
    logic [PRIO_W-1:0] prio_pool[4];

    always #5 aclk = ~aclk;

    task_table_scheduler #(.MAX_TASKS(MAX_TASKS)) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    tts_scoreboard #(.MAX_TASKS(MAX_TASKS), .M_W(M_W)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .waiting    (waiting),
        .checked    (checked)
    );

    // mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // stretches without any idling on either side
    always @(posedge aclk) begin
        cycle_no++;
        if (cycle_no % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge aclk) begin
        if (hold_left == 0 && !calm) hold_left = idle_len();
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) stuck = 0;
        else stuck++;
        if (stuck >= STUCK_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, stuck);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(input cmd_t cmd, input logic [KEY_W-1:0] k,
                                input logic [PRIO_W-1:0] p, input logic [TSTAT_W-1:0] st);
        int gap;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - KEY_W - PRIO_W - TSTAT_W){1'b0}}, st, p, k};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drain everything in flight before touching the policy register
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_policy(input logic v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        policy_writes++;
    endtask

    task automatic run_phase(input logic pol, input int n, input int add_pct);
        int r;
        cmd_t cmd;
        logic [KEY_W-1:0] k;
        logic [PRIO_W-1:0] p;
        logic [TSTAT_W-1:0] st;
        for (int i = 0; i < POOL_N; i++) key_pool[i] = 8'($urandom_range(0, 255));
        prio_pool[0] = 8'h00;
        prio_pool[1] = 8'hFF;
        prio_pool[2] = 8'($urandom_range(0, 255));
        prio_pool[3] = 8'($urandom_range(0, 255));
        write_policy(pol);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < add_pct) begin
                cmd = CMD_ADD;
            end else begin
                r = $urandom_range(0, 99);
                cmd = (r < 30) ? CMD_REMOVE : (r < 55) ? CMD_SET : CMD_PICK;
            end
            // small key pool so removes and updates hit, duplicates included
            k = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                            : key_pool[$urandom_range(0, POOL_N - 1)];
            p = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                     : prio_pool[$urandom_range(0, 3)];
            r = $urandom_range(0, 99);
            st = (r < 45) ? TS_READY : (r < 65) ? TS_RUNNING : (r < 90) ? TS_BLOCKED : TS_ODD;
            send_request(cmd, k, p, st);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // round robin on an empty table, then a mixed table
        write_policy(1'b0);
        send_request(CMD_PICK,   8'h12, 8'h00, TS_READY);
        send_request(CMD_REMOVE, 8'h12, 8'h00, TS_READY);
        send_request(CMD_SET,    8'h12, 8'h00, TS_RUNNING);
        send_request(CMD_ADD,    8'h00, 8'h00, TS_READY);
        send_request(CMD_ADD,    8'hFF, 8'hFF, TS_BLOCKED);
        send_request(CMD_ADD,    8'h00, 8'h80, TS_ODD);
        send_request(CMD_ADD,    8'hAA, 8'h55, TS_RUNNING);
        send_request(CMD_PICK,   8'h00, 8'h00, TS_READY);
        send_request(CMD_PICK,   8'hFF, 8'hFF, TS_ODD);
        send_request(CMD_SET,    8'hFF, 8'h00, TS_READY);
        send_request(CMD_PICK,   8'h00, 8'h00, TS_READY);
        send_request(CMD_REMOVE, 8'h00, 8'h00, TS_READY);
        send_request(CMD_SET,    8'h00, 8'h00, TS_BLOCKED);
        send_request(CMD_PICK,   8'h00, 8'h00, TS_READY);

        // priority mode on an unsorted table left by round robin
        write_policy(1'b1);
        send_request(CMD_ADD,    8'h10, 8'h55, TS_READY);
        send_request(CMD_ADD,    8'h11, 8'h00, TS_BLOCKED);
        send_request(CMD_ADD,    8'h12, 8'hFF, TS_ODD);
        send_request(CMD_PICK,   8'h00, 8'h00, TS_READY);
        send_request(CMD_SET,    8'h10, 8'h00, TS_BLOCKED);
        send_request(CMD_SET,    8'hFF, 8'h00, TS_ODD);
        send_request(CMD_SET,    8'hAA, 8'h00, TS_BLOCKED);
        send_request(CMD_PICK,   8'h00, 8'h00, TS_READY);
        send_request(CMD_REMOVE, 8'h77, 8'h00, TS_READY);

        // add-heavy phases fill the table, add-light ones drain it
        run_phase(1'b0, 150, 60);
        run_phase(1'b0, 150, 15);
        run_phase(1'b1, 150, 65);
        run_phase(1'b1, 150, 20);
        run_phase(1'b0, 100, 45);
        run_phase(1'b1, 150, 55);
        run_phase(1'b0, 150, 70);
        run_phase(1'b1, 150, 10);
        run_phase(1'b0, 100, 40);

        settle();
        repeat (45) @(posedge aclk);
        $display("Sent %0d scheduler requests across %0d policy settings, both policies.",
                 sent, policy_writes);
        $display("Compared %0d results field by field in order.", checked);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
